// ----- hw/rtl/stack_vm_instruction_step_macros.svh -----
// ----------------------------------------------------------------------------
// Stack VM assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STACK_VM_INSTRUCTION_STEP_MACROS_SVH
`define STACK_VM_INSTRUCTION_STEP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SVM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svm assertion failed");
// next-cycle implication
`define SVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svm assertion failed");
`else
`define SVM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SVM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// Types, constants and decode helpers of the stack VM step block.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int MEM_WORDS   = 32768;
    localparam int MEM_AW      = $clog2(MEM_WORDS);
    localparam int STACK_DEPTH = 1024;
    localparam int NUM_REGS    = 8;
    localparam int WORD_W      = 16;
    localparam int OP_LAST     = 21;

    typedef enum logic [4:0] {
        OP_HALT = 5'd0,  OP_SET  = 5'd1,  OP_PUSH = 5'd2,  OP_POP  = 5'd3,
        OP_EQ   = 5'd4,  OP_GT   = 5'd5,  OP_JMP  = 5'd6,  OP_JT   = 5'd7,
        OP_JF   = 5'd8,  OP_ADD  = 5'd9,  OP_MULT = 5'd10, OP_MOD  = 5'd11,
        OP_AND  = 5'd12, OP_OR   = 5'd13, OP_NOT  = 5'd14, OP_RMEM = 5'd15,
        OP_WMEM = 5'd16, OP_CALL = 5'd17, OP_RET  = 5'd18, OP_OUT  = 5'd19,
        OP_IN   = 5'd20, OP_NOOP = 5'd21
    } t_op;

    typedef enum logic [2:0] {
        H_RUN   = 3'd0, H_HALT  = 3'd1, H_IPRNG = 3'd2, H_BADOP = 3'd3,
        H_PAST  = 3'd4, H_OVF   = 3'd5, H_UNF   = 3'd6, H_MODZ  = 3'd7
    } t_halt;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OPC, S_OPND, S_EXEC, S_POP, S_RMEM, S_MOD, S_RESP
    } t_state;

    typedef struct packed {
        logic                mode;
        logic [MEM_AW-1:0]   load_address;
        logic [WORD_W-1:0]   load_word;
        logic [7:0]          in_char;
    } t_in_item;

    typedef struct packed {
        logic                out_valid;
        logic [7:0]          out_char;
        logic                used_input;
        logic [2:0]          halt_code;
        logic [WORD_W-1:0]   next_pc;
    } t_out_item;

    typedef struct packed {
        logic clr;
        logic load;
        logic begin_item;
        logic set_oor;
        logic fetch;
        logic opc;
        logic opnd;
        logic exec;
        logic pop_wb;
        logic rmem_wb;
        logic mod_wb;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic halted;
        logic pc_oor;
        logic bad_op;
        logic past_end;
        logic n_zero;
        logic more_opnd;
        logic ex_pop;
        logic ex_rmem;
        logic ex_mod;
        logic div_done;
    } t_status;

    function automatic logic [1:0] operand_count(input t_op op);
        logic [1:0] n;
        case (op)
            OP_HALT, OP_RET, OP_NOOP:                  n = 2'd0;
            OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT,
            OP_IN:                                     n = 2'd1;
            OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM,
            OP_WMEM:                                   n = 2'd2;
            default:                                   n = 2'd3;
        endcase
        return n;
    endfunction

endpackage

// ----- hw/rtl/svm_in_if.sv -----
// ----------------------------------------------------------------------------
// svm_in_if
// Input item channel: valid, ready and the input item.
// ----------------------------------------------------------------------------
interface svm_in_if;
    logic                valid;
    logic                ready;
    svm_pkg::t_in_item   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/svm_out_if.sv -----
// ----------------------------------------------------------------------------
// svm_out_if
// Result item channel: valid, ready and the result item.
// ----------------------------------------------------------------------------
interface svm_out_if;
    logic                valid;
    logic                ready;
    svm_pkg::t_out_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/stack_vm_instruction_step.sv -----
// Flow: a load or a halted or out-of-range step goes straight to the result;
//   a step fetches and decodes the opcode (bad opcode or operands past the end
//   stop there), fetches operands, executes and, for POP/RET/RMEM/MOD, writes
//   back (MOD via the serial remainder unit). One item at a time: the next is
//   taken after the result is taken. Reset: sync active low; clears registers,
//   pc, sp, halt; all 32768 memory words clear (one a cycle) before any item.
// ----------------------------------------------------------------------------
// stack_vm_instruction_step
// Top level: 16-bit register/stack VM executing at most one instruction per item.
// ----------------------------------------------------------------------------
`include "stack_vm_instruction_step_macros.svh"
module stack_vm_instruction_step #(
    parameter int STACK_DEPTH = svm_pkg::STACK_DEPTH,
    parameter int NUM_REGS    = svm_pkg::NUM_REGS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svm_in_if.sink     i_in,
    svm_out_if.source  o_out
);
    import svm_pkg::*;

    t_cmd    cmd;
    t_status status;

    svm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.data.mode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    svm_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_REGS    (NUM_REGS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in.data),
        .o_status (status),
        .o_result (o_out.data)
    );

    `SVM_ASSERT_NOW(a_one_at_a_time, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `SVM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `SVM_ASSERT_NOW(a_io_runs, i_clk, i_rst_n, o_out.valid && (o_out.data.out_valid || o_out.data.used_input), o_out.data.halt_code == H_RUN)
endmodule

// ----- hw/rtl/svm_mod.sv -----
// ----------------------------------------------------------------------------
// svm_mod
// Iterative restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module svm_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [svm_pkg::WORD_W-1:0] i_dividend,
    input  logic [svm_pkg::WORD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [svm_pkg::WORD_W-1:0] o_rem
);
    import svm_pkg::*;

    localparam int CW = $clog2(WORD_W);

    logic              r_act;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_div;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    assign shifted = {r_rem, r_quo[WORD_W-1]};
    assign diff    = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (r_act) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(WORD_W - 1)) begin
                    r_act  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_act) begin
            r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            r_rem <= diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ----- hw/rtl/svm_dp.sv -----
// ----------------------------------------------------------------------------
// svm_dp
// Datapath: main memory, register file, stack, program state and result.
// ----------------------------------------------------------------------------
module svm_dp #(
    parameter int STACK_DEPTH = svm_pkg::STACK_DEPTH,
    parameter int NUM_REGS    = svm_pkg::NUM_REGS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  svm_pkg::t_cmd       i_cmd,
    input  svm_pkg::t_in_item   i_item,
    output svm_pkg::t_status    o_status,
    output svm_pkg::t_out_item  o_result
);
    import svm_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int RIW = $clog2(NUM_REGS);

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] stk [STACK_DEPTH];
    logic [WORD_W-1:0] r_regs [NUM_REGS];

    logic [MEM_AW:0]   r_clr;
    logic [WORD_W-1:0] r_pc;
    logic [SPW-1:0]    r_sp;
    t_halt             r_halt;
    t_op               r_op;
    logic [1:0]        r_n;
    logic [1:0]        r_k;
    logic [MEM_AW-1:0] r_dst;
    logic [WORD_W-1:0] r_v [3];
    logic              r_isreg0;
    logic [RIW-1:0]    r_ri0;
    logic [7:0]        r_char;
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_stk_q;
    logic              r_ov;
    logic [7:0]        r_oc;
    logic              r_used;

    logic              mem_re;
    logic [MEM_AW-1:0] mem_ra;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              dst_we;
    logic [WORD_W-1:0] dst_wd;

    logic [WORD_W-1:0] va, vb, vc;
    logic [WORD_W-1:0] opnd_val;
    logic [1:0]        n_fetch;
    logic [MEM_AW:0]   end_chk;
    logic [WORD_W-1:0] pc_seq;
    logic [2*WORD_W-1:0] prod;
    logic              div_done;
    logic [WORD_W-1:0] div_rem;
    logic              div_start;
    logic              stk_full;
    logic              stk_empty;

    assign va = r_v[0];
    assign vb = r_v[1];
    assign vc = r_v[2];
    assign prod = vb * vc;
    assign pc_seq = r_pc + WORD_W'(r_n);
    assign stk_full  = (r_sp >= SPW'(STACK_DEPTH));
    assign stk_empty = (r_sp == '0);

    assign n_fetch = operand_count(t_op'(r_rdata[4:0]));
    assign end_chk = r_pc[MEM_AW:0] + (MEM_AW+1)'(1) + (MEM_AW+1)'(n_fetch);
    assign opnd_val = r_rdata[WORD_W-1] ? r_regs[r_rdata[RIW-1:0]] : r_rdata;
    assign div_start = i_cmd.exec && (r_op == OP_MOD) && (vc != '0);

    svm_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (vb),
        .i_divisor  (vc),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    always_comb begin
        o_status.clr_done  = r_clr[MEM_AW];
        o_status.halted    = (r_halt != H_RUN);
        o_status.pc_oor    = r_pc[WORD_W-1];
        o_status.bad_op    = (r_rdata > WORD_W'(OP_LAST));
        o_status.past_end  = (end_chk > (MEM_AW+1)'(MEM_WORDS));
        o_status.n_zero    = (n_fetch == 2'd0);
        o_status.more_opnd = ((r_k + 2'd1) < r_n);
        o_status.ex_pop    = ((r_op == OP_POP) || (r_op == OP_RET)) && !stk_empty;
        o_status.ex_rmem   = (r_op == OP_RMEM);
        o_status.ex_mod    = (r_op == OP_MOD) && (vc != '0);
        o_status.div_done  = div_done;
    end

    // memory read port
    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_pc[MEM_AW-1:0];
        if (i_cmd.fetch) begin
            mem_re = 1'b1;
        end else if (i_cmd.opc) begin
            mem_re = 1'b1;
            mem_ra = r_pc[MEM_AW-1:0] + MEM_AW'(1);
        end else if (i_cmd.opnd) begin
            mem_re = 1'b1;
            mem_ra = r_pc[MEM_AW-1:0] + MEM_AW'(r_k) + MEM_AW'(1);
        end else if (i_cmd.exec) begin
            mem_re = 1'b1;
            mem_ra = vb[MEM_AW-1:0];
        end
    end

    // destination value of the executing instruction
    always_comb begin
        dst_we = 1'b0;
        dst_wd = '0;
        if (i_cmd.exec) begin
            case (r_op)
                OP_SET:  begin dst_we = 1'b1; dst_wd = vb; end
                OP_EQ:   begin dst_we = 1'b1; dst_wd = WORD_W'(vb == vc); end
                OP_GT:   begin dst_we = 1'b1; dst_wd = WORD_W'(vb > vc); end
                OP_ADD:  begin dst_we = 1'b1; dst_wd = {1'b0, vb[14:0] + vc[14:0]}; end
                OP_MULT: begin dst_we = 1'b1; dst_wd = {1'b0, prod[14:0]}; end
                OP_AND:  begin dst_we = 1'b1; dst_wd = vb & vc; end
                OP_OR:   begin dst_we = 1'b1; dst_wd = vb | vc; end
                OP_NOT:  begin dst_we = 1'b1; dst_wd = {1'b0, ~vb[14:0]}; end
                OP_IN:   begin dst_we = 1'b1; dst_wd = {{8{r_char[7]}}, r_char}; end
                default: begin dst_we = 1'b0; dst_wd = '0; end
            endcase
        end else if (i_cmd.pop_wb) begin
            dst_we = (r_op == OP_POP);
            dst_wd = r_stk_q;
        end else if (i_cmd.rmem_wb) begin
            dst_we = 1'b1;
            dst_wd = r_rdata;
        end else if (i_cmd.mod_wb) begin
            dst_we = 1'b1;
            dst_wd = div_rem;
        end
    end

    // memory write port
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_dst;
        mem_wd = dst_wd;
        if (i_cmd.clr) begin
            mem_we = !r_clr[MEM_AW];
            mem_wa = r_clr[MEM_AW-1:0];
            mem_wd = '0;
        end else if (i_cmd.load) begin
            mem_we = 1'b1;
            mem_wa = i_item.load_address;
            mem_wd = i_item.load_word;
        end else if (i_cmd.exec && (r_op == OP_WMEM)) begin
            mem_we = 1'b1;
            mem_wa = va[MEM_AW-1:0];
            mem_wd = vb;
        end else if (dst_we && !r_isreg0) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !stk_full && ((r_op == OP_PUSH) || (r_op == OP_CALL))) begin
            stk[r_sp[SIW-1:0]] <= (r_op == OP_PUSH) ? va : pc_seq;
        end
        if (i_cmd.exec && !stk_empty) begin
            r_stk_q <= stk[SIW'(r_sp - SPW'(1))];
        end
    end

    // operand capture and item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_item) begin
            r_char <= i_item.in_char;
        end
        if (i_cmd.opc) begin
            r_op  <= t_op'(r_rdata[4:0]);
            r_n   <= n_fetch;
            r_dst <= r_pc[MEM_AW-1:0] + MEM_AW'(1);
        end
        if (i_cmd.opnd) begin
            r_v[r_k] <= opnd_val;
            if (r_k == 2'd0) begin
                r_isreg0 <= r_rdata[WORD_W-1];
                r_ri0    <= r_rdata[RIW-1:0];
            end
        end
    end

    // architectural control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_pc   <= '0;
            r_sp   <= '0;
            r_halt <= H_RUN;
            r_k    <= '0;
            r_ov   <= 1'b0;
            r_oc   <= '0;
            r_used <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_cmd.clr && !r_clr[MEM_AW]) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.begin_item) begin
                r_ov   <= 1'b0;
                r_oc   <= '0;
                r_used <= 1'b0;
            end
            if (i_cmd.set_oor) begin
                r_halt <= H_IPRNG;
            end
            if (i_cmd.opc) begin
                r_k <= '0;
                if (o_status.bad_op) begin
                    r_halt <= H_BADOP;
                end else begin
                    r_pc <= r_pc + WORD_W'(1);
                    if (o_status.past_end) begin
                        r_halt <= H_PAST;
                    end
                end
            end
            if (i_cmd.opnd) begin
                r_k <= r_k + 2'd1;
            end
            if (dst_we && r_isreg0) begin
                r_regs[r_ri0] <= dst_wd;
            end
            if (i_cmd.exec) begin
                r_pc <= pc_seq;
                case (r_op)
                    OP_HALT: r_halt <= H_HALT;
                    OP_PUSH: begin
                        if (stk_full) r_halt <= H_OVF;
                        else          r_sp <= r_sp + SPW'(1);
                    end
                    OP_CALL: begin
                        if (stk_full) r_halt <= H_OVF;
                        else          r_sp <= r_sp + SPW'(1);
                        r_pc <= va;
                    end
                    OP_POP, OP_RET: begin
                        if (stk_empty) r_halt <= H_UNF;
                        else           r_sp <= r_sp - SPW'(1);
                    end
                    OP_MOD:  if (vc == '0) r_halt <= H_MODZ;
                    OP_JMP:  r_pc <= va;
                    OP_JT:   if (va != '0) r_pc <= vb;
                    OP_JF:   if (va == '0) r_pc <= vb;
                    OP_OUT: begin
                        r_ov <= 1'b1;
                        r_oc <= va[7:0];
                    end
                    OP_IN:   r_used <= 1'b1;
                    default: ;
                endcase
            end
            if (i_cmd.pop_wb && (r_op == OP_RET)) begin
                r_pc <= r_stk_q;
            end
        end
    end

    always_comb begin
        o_result.out_valid  = r_ov;
        o_result.out_char   = r_oc;
        o_result.used_input = r_used;
        o_result.halt_code  = r_halt;
        o_result.next_pc    = r_pc;
    end
endmodule

// ----- hw/rtl/svm_ctrl.sv -----
// ----------------------------------------------------------------------------
// svm_ctrl
// Sequencer: memory clear, fetch, operand fetch, execute, writeback and result hold.
// ----------------------------------------------------------------------------
module svm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  svm_pkg::t_status  i_status,
    output svm_pkg::t_cmd     o_cmd
);
    import svm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.begin_item = 1'b1;
                    n_state = S_RESP;
                    if (!i_in_mode) begin
                        o_cmd.load = 1'b1;
                    end else if (!i_status.halted) begin
                        if (i_status.pc_oor) begin
                            o_cmd.set_oor = 1'b1;
                        end else begin
                            o_cmd.fetch = 1'b1;
                            n_state = S_OPC;
                        end
                    end
                end
            end
            S_OPC: begin
                o_cmd.opc = 1'b1;
                if (i_status.bad_op || i_status.past_end) n_state = S_RESP;
                else if (i_status.n_zero)                 n_state = S_EXEC;
                else                                      n_state = S_OPND;
            end
            S_OPND: begin
                o_cmd.opnd = 1'b1;
                if (!i_status.more_opnd) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.ex_pop)       n_state = S_POP;
                else if (i_status.ex_rmem) n_state = S_RMEM;
                else if (i_status.ex_mod)  n_state = S_MOD;
                else                       n_state = S_RESP;
            end
            S_POP: begin
                o_cmd.pop_wb = 1'b1;
                n_state = S_RESP;
            end
            S_RMEM: begin
                o_cmd.rmem_wb = 1'b1;
                n_state = S_RESP;
            end
            S_MOD: begin
                if (i_status.div_done) begin
                    o_cmd.mod_wb = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

// ----- tb/svm_step_checker.sv -----
// ----------------------------------------------------------------------------
// svm_step_checker
// Watches both item channels, predicts every result of the stack VM step
// block from its own copy of memory, registers, stack and pc, and compares.
// ----------------------------------------------------------------------------
module svm_step_checker
    import svm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    svm_in_if                 in_ch,
    svm_out_if                out_ch,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_out_count,
    output logic [15:0]       o_pc,
    output logic [10:0]       o_sp,
    output logic [2:0]        o_halt,
    output logic [7:0][15:0]  o_regs,
    output logic [15:0]       o_stack_top
);

    logic [15:0]      vm_mem [MEM_WORDS];
    logic [7:0][15:0] gpr;
    logic [15:0]      ret_stack [STACK_DEPTH];
    logic [15:0]      vm_pc;
    logic [10:0]      vm_sp;
    t_halt            vm_halt;
    t_out_item        result_q [$];
    int               fails;
    int               checked;
    int               outs;

    assign o_fail_count = fails;
    assign o_pending    = result_q.size();
    assign o_checked    = checked;
    assign o_out_count  = outs;
    assign o_pc         = vm_pc;
    assign o_sp         = vm_sp;
    assign o_halt       = vm_halt;
    assign o_regs       = gpr;
    assign o_stack_top  = (vm_sp == 0) ? 16'h0 : ret_stack[vm_sp - 1];

    function automatic int unsigned arity(input t_op op);
        case (op)
            OP_HALT, OP_RET, OP_NOOP:                             return 0;
            OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN:      return 1;
            OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM:       return 2;
            default:                                              return 3;
        endcase
    endfunction

    // locations at or above MEM_WORDS are registers
    function automatic int unsigned loc_rd(input int unsigned loc);
        if (loc >= MEM_WORDS)
            return gpr[loc - MEM_WORDS];
        return vm_mem[loc];
    endfunction

    task automatic loc_wr(input int unsigned loc, input int unsigned v);
        if (loc >= MEM_WORDS)
            gpr[loc - MEM_WORDS] = v[15:0];
        else
            vm_mem[loc] = v[15:0];
    endtask

    task automatic run_item(input t_in_item it, output t_out_item r);
        int unsigned p, n, a, b, c;
        int unsigned loc [3];
        logic [15:0] w;
        t_op op;
        r = '0;
        if (!it.mode) begin
            vm_mem[it.load_address] = it.load_word;
        end else if (vm_halt == H_RUN) begin
            p = vm_pc;
            if (p >= MEM_WORDS) begin
                vm_halt = H_IPRNG;
            end else if (vm_mem[p] > OP_LAST) begin
                vm_halt = H_BADOP;
            end else begin
                op = t_op'(vm_mem[p][4:0]);
                n = arity(op);
                p++;
                if (p + n > MEM_WORDS) begin
                    vm_halt = H_PAST;
                    vm_pc = p[15:0];
                end else begin
                    loc = '{0, 0, 0};
                    for (int i = 0; i < n; i++) begin
                        w = vm_mem[p];
                        loc[i] = w[15] ? MEM_WORDS + w[2:0] : p;
                        p++;
                    end
                    a = loc_rd(loc[0]);
                    b = loc_rd(loc[1]);
                    c = loc_rd(loc[2]);
                    case (op)
                        OP_HALT: vm_halt = H_HALT;
                        OP_SET:  loc_wr(loc[0], b);
                        OP_PUSH: begin
                            if (vm_sp >= STACK_DEPTH) vm_halt = H_OVF;
                            else begin ret_stack[vm_sp] = a[15:0]; vm_sp++; end
                        end
                        OP_POP: begin
                            if (vm_sp == 0) vm_halt = H_UNF;
                            else begin vm_sp--; loc_wr(loc[0], ret_stack[vm_sp]); end
                        end
                        OP_EQ:   loc_wr(loc[0], (b == c) ? 1 : 0);
                        OP_GT:   loc_wr(loc[0], (b > c) ? 1 : 0);
                        OP_JMP:  p = a;
                        OP_JT:   if (a != 0) p = b;
                        OP_JF:   if (a == 0) p = b;
                        OP_ADD:  loc_wr(loc[0], (b + c) & 32'h7FFF);
                        OP_MULT: loc_wr(loc[0], (b * c) & 32'h7FFF);
                        OP_MOD: begin
                            if (c == 0) vm_halt = H_MODZ;
                            else loc_wr(loc[0], b % c);
                        end
                        OP_AND:  loc_wr(loc[0], b & c);
                        OP_OR:   loc_wr(loc[0], b | c);
                        OP_NOT:  loc_wr(loc[0], ~b & 32'h7FFF);
                        OP_RMEM: loc_wr(loc[0], vm_mem[b[14:0]]);
                        OP_WMEM: vm_mem[a[14:0]] = b[15:0];
                        OP_CALL: begin
                            // overflow still jumps
                            if (vm_sp >= STACK_DEPTH) vm_halt = H_OVF;
                            else begin ret_stack[vm_sp] = p[15:0]; vm_sp++; end
                            p = a;
                        end
                        OP_RET: begin
                            if (vm_sp == 0) vm_halt = H_UNF;
                            else begin vm_sp--; p = ret_stack[vm_sp]; end
                        end
                        OP_OUT: begin
                            r.out_valid = 1'b1;
                            r.out_char  = a[7:0];
                        end
                        OP_IN: begin
                            loc_wr(loc[0], {{8{it.in_char[7]}}, it.in_char});
                            r.used_input = 1'b1;
                        end
                        default: ;
                    endcase
                    vm_pc = p[15:0];
                end
            end
        end
        r.halt_code = vm_halt;
        r.next_pc   = vm_pc;
    endtask

    task automatic check_field(input string name, input int unsigned e, input int unsigned a);
        if (e != a) begin
            $error("%s mismatch: expected %0h, actual %0h", name, e, a);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item r;
        if (!i_rst_n) begin
            foreach (vm_mem[i]) vm_mem[i] = '0;
            gpr     = '0;
            vm_pc   = '0;
            vm_sp   = '0;
            vm_halt = H_RUN;
            result_q.delete();
            fails   = 0;
            checked = 0;
            outs    = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (result_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fails++;
                end else begin
                    e = result_q.pop_front();
                    check_field("out_valid", e.out_valid, out_ch.data.out_valid);
                    check_field("out_char", e.out_char, out_ch.data.out_char);
                    check_field("used_input", e.used_input, out_ch.data.used_input);
                    check_field("halt_code", e.halt_code, out_ch.data.halt_code);
                    check_field("next_pc", e.next_pc, out_ch.data.next_pc);
                    checked++;
                    if (e.out_valid) outs++;
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                run_item(in_ch.data, r);
                result_q.push_back(r);
            end
        end
    end

endmodule

// ----- tb/stack_vm_instruction_step_tb.sv -----
// ----------------------------------------------------------------------------
// stack_vm_instruction_step_tb
// Loads small random programs a word at a time and steps through them,
// steering around halts until a final randomly chosen halt; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module stack_vm_instruction_step_tb;
    import svm_pkg::*;

    localparam int SAFE_PC    = 32000;
    localparam int IDLE_LIMIT = 200000;
    localparam int N_ITEMS    = 1150;

    logic i_clk;
    logic i_rst_n;

    svm_in_if  in_ch ();
    svm_out_if out_ch ();

    int               fail_count, pending, checked, out_count;
    logic [15:0]      m_pc, m_stack_top;
    logic [10:0]      m_sp;
    logic [2:0]       m_halt;
    logic [7:0][15:0] m_regs;

    int items;
    bit calm;
    bit hold_req;

    stack_vm_instruction_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    svm_step_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_out_count  (out_count),
        .o_pc         (m_pc),
        .o_sp         (m_sp),
        .o_halt       (m_halt),
        .o_regs       (m_regs),
        .o_stack_top  (m_stack_top)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stalls, plus a long hold-off on each request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Called at a rising edge. After a step the valid is dropped for a cycle so
    // that the checker's machine state is settled before the next item is built.
    task automatic send(input t_in_item it);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items++;
        if (it.mode) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
            @(posedge i_clk);
        end else if (!calm && $urandom_range(0, 99) < 35) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic load(input logic [14:0] addr, input logic [15:0] word);
        send('{mode: 1'b0, load_address: addr, load_word: word, in_char: 8'($urandom)});
    endtask

    task automatic step(input logic [7:0] ch);
        send('{mode: 1'b1, load_address: 15'($urandom), load_word: 16'($urandom),
               in_char: ch});
    endtask

    // writes the instruction at the current pc and executes it
    task automatic issue(input logic [15:0] opw, input logic [15:0] w0,
                         input logic [15:0] w1, input logic [15:0] w2,
                         input logic [7:0] ch);
        logic [15:0] w [3];
        int unsigned p, n;
        w = '{w0, w1, w2};
        p = m_pc;
        n = (opw <= OP_LAST) ? operand_count(t_op'(opw[4:0])) : 0;
        load(p[14:0], opw);
        for (int i = 0; i < n; i++) load(15'(p + 1 + i), w[i]);
        step(ch);
    endtask

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return {1'b1, 15'($urandom)};
            4:          return 16'h0000;
            5:          return 16'h7FFF;
            default:    return {1'b0, 15'($urandom)};
        endcase
    endfunction

    function automatic logic [15:0] value_of(input logic [15:0] w);
        return w[15] ? m_regs[w[2:0]] : w;
    endfunction

    function automatic logic [15:0] safe_target();
        return 16'($urandom_range(0, SAFE_PC - 1));
    endfunction

    task automatic rebase();
        if (m_pc >= SAFE_PC) issue(16'(OP_JMP), safe_target(), 16'h0, 16'h0, 8'h0);
    endtask

    // executes op with random operands, steering clear of any halt (a POP or PUSH may stand in for it)
    task automatic run_op(input t_op op_in, input logic [7:0] ch);
        t_op op;
        logic [15:0] w [3];
        op = op_in;
        rebase();
        foreach (w[i]) w[i] = rand_operand();
        if ((op == OP_POP || op == OP_RET) && m_sp == 0) op = OP_PUSH;
        if ((op == OP_PUSH || op == OP_CALL) && m_sp >= STACK_DEPTH) op = OP_POP;
        if (op == OP_RET && m_stack_top >= SAFE_PC) op = OP_POP;
        if ((op == OP_JMP || op == OP_CALL) && value_of(w[0]) >= SAFE_PC) w[0] = safe_target();
        if ((op == OP_JT || op == OP_JF) && value_of(w[1]) >= SAFE_PC) w[1] = safe_target();
        if (op == OP_MOD && value_of(w[2]) == 0) w[2] = 16'($urandom_range(1, 32767));
        issue(16'(op), w[0], w[1], w[2], ch);
    endtask

    task automatic final_halt();
        int unsigned p;
        rebase();
        case ($urandom_range(1, 7))
            1: issue(16'(OP_HALT), 16'h0, 16'h0, 16'h0, 8'h0);
            2: begin
                // 0xFF sign-extends to 0xFFFF, a pc past the end of memory
                issue(16'(OP_IN), 16'h8000, 16'h0, 16'h0, 8'hFF);
                issue(16'(OP_JMP), 16'h8000, 16'h0, 16'h0, 8'h0);
                step(8'h0);
            end
            3: issue(16'($urandom_range(OP_LAST + 1, 65535)), 16'h0, 16'h0, 16'h0, 8'h0);
            4: begin
                issue(16'(OP_JMP), 16'h7FFF, 16'h0, 16'h0, 8'h0);
                load(15'h7FFF, 16'(OP_ADD));
                step(8'h0);
            end
            5: begin
                if (m_sp + 40 < STACK_DEPTH) begin
                    // stack too shallow for a short overflow run
                    issue(16'(OP_MOD), rand_operand(), rand_operand(), 16'h0000, 8'h0);
                end else begin
                    // CALL to itself until the stack overflows
                    p = m_pc;
                    load(p[14:0], 16'(OP_CALL));
                    load(15'(p + 1), p[15:0]);
                    while (m_halt == H_RUN) step(8'($urandom));
                end
            end
            6: begin
                while (m_sp != 0 && m_halt == H_RUN)
                    issue(16'(OP_POP), rand_operand(), 16'h0, 16'h0, 8'h0);
                issue(16'(OP_POP), rand_operand(), 16'h0, 16'h0, 8'h0);
            end
            default: issue(16'(OP_MOD), rand_operand(), rand_operand(), 16'h0000, 8'h0);
        endcase
    endtask

    initial begin
        int sel;
        items    = 0;
        calm     = 1'b0;
        hold_req = 1'b0;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every operation but HALT once, then IN at the character extremes
        for (int op = OP_SET; op <= OP_NOOP; op++) run_op(t_op'(op), 8'($urandom));
        run_op(OP_IN, 8'h00);
        run_op(OP_IN, 8'h7F);
        run_op(OP_IN, 8'h80);
        run_op(OP_IN, 8'hFF);
        issue(16'(OP_OUT), 16'h7FFF, 16'h0, 16'h0, 8'h0);

        while (items < N_ITEMS) begin
            calm = (items >= 350 && items < 500);
            if (items >= 600 && items < 606) hold_req = 1'b1;
            if (items >= 800 && items < 806) begin
                while (pending != 0) @(posedge i_clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 10)
                load(15'($urandom), 16'($urandom));
            else if (sel < 14) begin
                // bare step over a NOOP placed at the pc
                rebase();
                load(m_pc[14:0], 16'(OP_NOOP));
                step(8'($urandom));
            end else
                run_op(t_op'($urandom_range(OP_SET, OP_NOOP)), 8'($urandom));
        end

        final_halt();
        // halted machine: steps report the stored state, loads still land
        repeat (10) begin
            if ($urandom_range(0, 1)) step(8'($urandom));
            else load(15'($urandom), 16'($urandom));
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run: %0d items driven, %0d results checked, %0d OUT results",
                 items, checked, out_count);
        $display("run: stack depth reached %0d, machine stopped with halt code %0d",
                 m_sp, m_halt);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
